/* hw/rtl/crwb_pkg.sv */
// package for the corner reference white balance block
// holds widths, codes, state encoding and the command/status structs
// used by all modules of the block, no dependencies
package crwb_pkg;

   localparam int MAX_DIM_DEF = 512;

   localparam int ACTION_W  = 2;
   localparam int COORD_W   = 9;
   localparam int PIX_W     = 8;
   localparam int PATCH_W   = 9;
   localparam int DIM_W     = 10;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 10;
   localparam int SUM_W     = 24;
   localparam int FACT_W    = 24;
   localparam int AREA_W    = 2 * PATCH_W;
   localparam int DIV_W     = 26;
   localparam int FRAC_W    = 16;
   localparam int NUM_CORNERS = 4;
   localparam int NUM_CHANS   = 3;
   localparam int PROD_W    = PIX_W + FACT_W;

   localparam logic [FACT_W-1:0] FACT_MAX = '1;
   localparam logic [PIX_W-1:0]  PIX_MAX  = '1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_GATHER = 2'd1,
      ACT_FINISH = 2'd2,
      ACT_SCALE  = 2'd3
   } crwb_action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REF_BLUE     = 3'd0,
      CSR_REF_GREEN    = 3'd1,
      CSR_REF_RED      = 3'd2,
      CSR_PATCH_SIZE   = 3'd3,
      CSR_IMAGE_WIDTH  = 3'd4,
      CSR_IMAGE_HEIGHT = 3'd5
   } crwb_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AVG_START,
      ST_AVG_WAIT,
      ST_FACT_START,
      ST_FACT_WAIT
   } crwb_state_type;

   typedef struct packed {
      logic       clear_sums;
      logic       gather;
      logic       scale;
      logic       acc_clear;
      logic       acc_add;
      logic       div_start;
      logic       div_sel_fact;
      logic       fact_write;
      logic [1:0] corner;
      logic [1:0] chan;
   } crwb_cmd_type;

   typedef struct packed {
      logic area_zero;
      logic acc_zero;
      logic div_done;
   } crwb_stat_type;

endpackage

/* hw/rtl/corner_reference_white_balance.sv */
// White balance against a reference color seen in the four image corners.
// Input channel req_*: valid/stall, one transaction per item, action selects
// clear sums, gather pixel, finish factors or scale pixel.
// Result channel rsp_*: valid/stall, one transaction per scale item only.
// Config channel csr_*: valid/ready write of one register by index, always
// ready; write only while no finish is running.
// Clear and gather can follow back to back.
// Scale: the result sits in the output register the cycle after acceptance;
// outside finish, a scale item is held off only while that register is full and stalled,
// other items still enter.
// Finish: runs the shared one-bit-per-cycle divider 15 times (12 corner
// averages, 3 factors), during which req_stall stays high. A zero patch
// size or zero average sum skips the corresponding divisions.
// Reset (synchronous, active high) restores register defaults, clears all
// sums and factors and empties the output register.
// Uses crwb_pkg, crwb_ctrl, crwb_dp and crwb_div.
module corner_reference_white_balance
   import crwb_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [ACTION_W-1:0]  req_action,
   input  logic [COORD_W-1:0]   req_pixel_row,
   input  logic [COORD_W-1:0]   req_pixel_col,
   input  logic [PIX_W-1:0]     req_blue_in,
   input  logic [PIX_W-1:0]     req_green_in,
   input  logic [PIX_W-1:0]     req_red_in,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [PIX_W-1:0]     rsp_blue_out,
   output logic [PIX_W-1:0]     rsp_green_out,
   output logic [PIX_W-1:0]     rsp_red_out,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   crwb_cmd_type  cmd;
   crwb_stat_type stat;
   logic          busy;

   assign csr_ready = 1'b1;

   crwb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy)
   );

   crwb_dp #(
      .MAX_DIM (MAX_DIM)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .csr_we        (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_pixel_row (req_pixel_row),
      .req_pixel_col (req_pixel_col),
      .req_blue_in   (req_blue_in),
      .req_green_in  (req_green_in),
      .req_red_in    (req_red_in),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_green_out (rsp_green_out),
      .rsp_red_out   (rsp_red_out)
   );

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      busy |-> req_stall)
      else $error("transaction accepted during finish");

   a_finish_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_action == ACT_FINISH) |=> busy)
      else $error("finish transaction did not start the sequencer");

   a_div_in_finish: assert property (@(posedge clock) disable iff (reset)
      (stat.div_done || cmd.fact_write || cmd.div_start) |-> busy)
      else $error("divider activity outside finish");

   a_scale_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_action == ACT_SCALE) |=> rsp_valid)
      else $error("scale transaction gave no result");

endmodule

/* hw/rtl/crwb_div.sv */
// restoring divider, one quotient bit per cycle
// depends on crwb_pkg for the operand width
module crwb_div
   import crwb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIV_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dq_ff, dq_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;
   logic [DIV_W:0]   trial;
   logic             fits;

   always_comb begin
      trial   = {rem_ff, dq_ff[DIV_W-1]};
      fits    = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dq_in   = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_W'(trial - {1'b0, dvs_ff}) : trial[DIV_W-1:0];
         dq_in  = {dq_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule

/* hw/rtl/crwb_dp.sv */
// datapath: config registers, corner sums, average/factor accumulation,
// channel factors and the scaling multipliers; uses crwb_pkg and crwb_div
module crwb_dp
   import crwb_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
)(
   input  logic                 clock,
   input  logic                 reset,
   input  crwb_cmd_type         cmd,
   output crwb_stat_type        stat,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   input  logic [COORD_W-1:0]   req_pixel_row,
   input  logic [COORD_W-1:0]   req_pixel_col,
   input  logic [PIX_W-1:0]     req_blue_in,
   input  logic [PIX_W-1:0]     req_green_in,
   input  logic [PIX_W-1:0]     req_red_in,
   output logic [PIX_W-1:0]     rsp_blue_out,
   output logic [PIX_W-1:0]     rsp_green_out,
   output logic [PIX_W-1:0]     rsp_red_out
);

   localparam int CMP_W = $clog2(MAX_DIM + 1) + DIM_W;
   localparam logic [CMP_W-1:0] MAX_DIM_C = CMP_W'(MAX_DIM);

   logic [PIX_W-1:0]   ref_ff [NUM_CHANS];
   logic [PATCH_W-1:0] patch_ff;
   logic [DIM_W-1:0]   width_ff;
   logic [DIM_W-1:0]   height_ff;

   logic [SUM_W-1:0]   sums_ff [NUM_CORNERS][NUM_CHANS];
   logic [FACT_W-1:0]  fact_ff [NUM_CHANS];
   logic [DIV_W-1:0]   acc_ff, acc_in;
   logic [PIX_W-1:0]   out_ff [NUM_CHANS];

   logic [DIM_W-1:0]   w_lim, h_lim;
   logic [DIM_W-1:0]   row_x, col_x, patch_x;
   logic               in_frame, up, down, left, right;
   logic [NUM_CORNERS-1:0] in_corner;
   logic [PIX_W-1:0]   px [NUM_CHANS];
   logic [AREA_W-1:0]  area;
   logic [DIV_W-1:0]   div_dividend, div_divisor, div_q;
   logic               div_done;
   logic [FACT_W-1:0]  fact_val;
   logic [PROD_W-1:0]  prod [NUM_CHANS];
   logic [PIX_W-1:0]   sat [NUM_CHANS];

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff[0] <= PIX_MAX;
         ref_ff[1] <= PIX_MAX;
         ref_ff[2] <= PIX_MAX;
         patch_ff  <= PATCH_W'(102);
         width_ff  <= DIM_W'(512);
         height_ff <= DIM_W'(512);
      end else if (csr_we) begin
         unique case (crwb_csr_type'(csr_index))
            CSR_REF_BLUE:     ref_ff[0] <= csr_wdata[PIX_W-1:0];
            CSR_REF_GREEN:    ref_ff[1] <= csr_wdata[PIX_W-1:0];
            CSR_REF_RED:      ref_ff[2] <= csr_wdata[PIX_W-1:0];
            CSR_PATCH_SIZE:   patch_ff  <= csr_wdata[PATCH_W-1:0];
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // patch membership
   always_comb begin
      w_lim = (CMP_W'(width_ff) > MAX_DIM_C) ? MAX_DIM_C[DIM_W-1:0] : width_ff;
      h_lim = (CMP_W'(height_ff) > MAX_DIM_C) ? MAX_DIM_C[DIM_W-1:0] : height_ff;
      row_x   = DIM_W'(req_pixel_row);
      col_x   = DIM_W'(req_pixel_col);
      patch_x = DIM_W'(patch_ff);
      in_frame = (row_x < h_lim) && (col_x < w_lim);
      up    = row_x < patch_x;
      left  = col_x < patch_x;
      down  = (row_x + patch_x) >= h_lim;
      right = (col_x + patch_x) >= w_lim;
      in_corner[0] = up && left;
      in_corner[1] = up && right;
      in_corner[2] = down && left;
      in_corner[3] = down && right;
      px[0] = req_blue_in;
      px[1] = req_green_in;
      px[2] = req_red_in;
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_sums) begin
         for (int c = 0; c < NUM_CORNERS; c++) begin
            for (int ch = 0; ch < NUM_CHANS; ch++) begin
               sums_ff[c][ch] <= '0;
            end
         end
      end else if (cmd.gather && in_frame) begin
         for (int c = 0; c < NUM_CORNERS; c++) begin
            if (in_corner[c]) begin
               for (int ch = 0; ch < NUM_CHANS; ch++) begin
                  sums_ff[c][ch] <= sums_ff[c][ch] + SUM_W'(px[ch]);
               end
            end
         end
      end
   end

   // averages and factors through the shared divider
   always_comb begin
      area = AREA_W'(patch_ff) * AREA_W'(patch_ff);
      if (cmd.div_sel_fact) begin
         div_dividend = {ref_ff[cmd.chan], (DIV_W - PIX_W)'(0)};
         div_divisor  = acc_ff;
      end else begin
         div_dividend = DIV_W'(sums_ff[cmd.corner][cmd.chan]);
         div_divisor  = DIV_W'(area);
      end
      acc_in = acc_ff;
      if (cmd.acc_clear) begin
         acc_in = '0;
      end else if (cmd.acc_add) begin
         acc_in = acc_ff + div_q;
      end
      if (stat.acc_zero || (|div_q[DIV_W-1:FACT_W])) begin
         fact_val = FACT_MAX;
      end else begin
         fact_val = div_q[FACT_W-1:0];
      end
   end

   crwb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (reset) begin
         for (int ch = 0; ch < NUM_CHANS; ch++) begin
            fact_ff[ch] <= '0;
         end
      end else if (cmd.fact_write) begin
         fact_ff[cmd.chan] <= fact_val;
      end
   end

   assign stat.area_zero = (patch_ff == '0);
   assign stat.acc_zero  = (acc_ff == '0);
   assign stat.div_done  = div_done;

   // scaling
   always_comb begin
      for (int ch = 0; ch < NUM_CHANS; ch++) begin
         prod[ch] = PROD_W'(px[ch]) * PROD_W'(fact_ff[ch]);
         sat[ch]  = (|prod[ch][PROD_W-1:FRAC_W+PIX_W]) ? PIX_MAX
                                                      : prod[ch][FRAC_W+PIX_W-1:FRAC_W];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         for (int ch = 0; ch < NUM_CHANS; ch++) begin
            out_ff[ch] <= sat[ch];
         end
      end
   end

   assign rsp_blue_out  = out_ff[0];
   assign rsp_green_out = out_ff[1];
   assign rsp_red_out   = out_ff[2];

endmodule

/* hw/rtl/crwb_ctrl.sv */
// controller: input/output handshake and the finish sequencer
// drives the datapath through crwb_cmd_type, depends on crwb_pkg
module crwb_ctrl
   import crwb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [ACTION_W-1:0] req_action,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  crwb_stat_type       stat,
   output crwb_cmd_type        cmd,
   output logic                busy
);

   crwb_state_type state_ff, state_in;
   logic [1:0]     corner_ff, corner_in;
   logic [1:0]     chan_ff, chan_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           accept;
   crwb_action_type action;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         corner_ff    <= '0;
         chan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         corner_ff    <= corner_in;
         chan_ff      <= chan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      action    = crwb_action_type'(req_action);
      state_in  = state_ff;
      corner_in = corner_ff;
      chan_in   = chan_ff;
      cmd       = '0;
      cmd.corner = corner_ff;
      cmd.chan   = chan_ff;
      req_stall = 1'b1;
      accept    = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            // a scale transaction waits only for room in the output register
            req_stall = (action == ACT_SCALE) && rsp_valid_ff && rsp_stall;
            accept    = req_valid && !req_stall;
            if (accept) begin
               unique case (action)
                  ACT_CLEAR:  cmd.clear_sums = 1'b1;
                  ACT_GATHER: cmd.gather = 1'b1;
                  ACT_SCALE: begin
                     cmd.scale    = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  ACT_FINISH: begin
                     cmd.acc_clear = 1'b1;
                     corner_in = '0;
                     chan_in   = '0;
                     state_in  = ST_AVG_START;
                  end
                  default: ;
               endcase
            end
         end
         ST_AVG_START: begin
            if (stat.area_zero) begin
               corner_in = corner_ff + 1'b1;
               if (corner_ff == 2'd3) begin
                  state_in = ST_FACT_START;
               end
            end else begin
               cmd.div_start = 1'b1;
               state_in = ST_AVG_WAIT;
            end
         end
         ST_AVG_WAIT: begin
            if (stat.div_done) begin
               cmd.acc_add = 1'b1;
               corner_in = corner_ff + 1'b1;
               state_in  = (corner_ff == 2'd3) ? ST_FACT_START : ST_AVG_START;
            end
         end
         ST_FACT_START: begin
            cmd.div_sel_fact = 1'b1;
            if (stat.acc_zero) begin
               cmd.fact_write = 1'b1;
               chan_in   = chan_ff + 1'b1;
               corner_in = '0;
               cmd.acc_clear = 1'b1;
               state_in  = (chan_ff == 2'd2) ? ST_IDLE : ST_AVG_START;
            end else begin
               cmd.div_start = 1'b1;
               state_in = ST_FACT_WAIT;
            end
         end
         ST_FACT_WAIT: begin
            cmd.div_sel_fact = 1'b1;
            if (stat.div_done) begin
               cmd.fact_write = 1'b1;
               chan_in   = chan_ff + 1'b1;
               corner_in = '0;
               cmd.acc_clear = 1'b1;
               state_in  = (chan_ff == 2'd2) ? ST_IDLE : ST_AVG_START;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign busy      = (state_ff != ST_IDLE);

endmodule
